// ----- hdl/voxel_grid_first_point_filter_assert.svh -----
// assertion macros for the voxel grid first point filter checker
// used only by the checker file, no other dependencies
`ifndef VOXEL_GRID_FIRST_POINT_FILTER_ASSERT_SVH
`define VOXEL_GRID_FIRST_POINT_FILTER_ASSERT_SVH
// property that must hold at every clock edge outside reset
`define VGF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked from the cycle after the antecedent
`define VGF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/vgf_pkg.sv -----
// shared constants and helpers for the voxel grid first point filter
// no dependencies
`default_nettype none
package vgf_pkg;
  localparam int VGF_TABLE_SLOTS = 4096;
  localparam int VGF_EPOCH_W     = 8;
  localparam int VGF_CFG_IDX_W   = 8;
  localparam int VGF_AXIS_W      = 21;
  localparam int VGF_KEY_W       = 3 * VGF_AXIS_W;

  localparam logic [VGF_CFG_IDX_W-1:0] REG_INV_VOXEL  = 8'd0;
  localparam logic [VGF_CFG_IDX_W-1:0] REG_DROP_INVAL = 8'd1;

  localparam logic [31:0] INV_VOXEL_RESET = 32'h0001_0000;
  localparam logic [63:0] HASH_MUL        = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [31:0] AXIS_MAX     = 32'd1048575;
  localparam logic [31:0] AXIS_MIN_MAG = 32'd1048576;

  // saturate the scaled magnitude and restore the sign
  function automatic logic [VGF_AXIS_W-1:0] axis_key(input logic [31:0] q, input logic neg);
    logic [31:0] qs;
    logic [31:0] t;
    if (neg) begin
      qs = (q > AXIS_MIN_MAG) ? AXIS_MIN_MAG : q;
      t  = 32'd0 - qs;
    end else begin
      t  = (q > AXIS_MAX) ? AXIS_MAX : q;
    end
    return t[VGF_AXIS_W-1:0];
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/vgf_if.sv -----
// handshake channels of the voxel grid first point filter
// uses vgf_pkg for the configuration index width
`default_nettype none
interface vgf_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_index;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] coord_z;
  logic        point_invalid;
  logic        frame_end;
  modport source(output valid, point_index, coord_x, coord_y, coord_z, point_invalid,
                 frame_end, input ready);
  modport sink(input valid, point_index, coord_x, coord_y, coord_z, point_invalid,
               frame_end, output ready);
endinterface

interface vgf_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_index;
  logic        keep;
  logic        table_overflow;
  logic        frame_done;
  modport source(output valid, kept_index, keep, table_overflow, frame_done, input ready);
  modport sink(input valid, kept_index, keep, table_overflow, frame_done, output ready);
endinterface

interface vgf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vgf_pkg::VGF_CFG_IDX_W-1:0] index;
  logic [31:0]                       data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/voxel_grid_first_point_filter.sv -----
// per point: scaling and hashing on the shared multiplier, then a table read and compare per probe
// one point in flight at a time, bounded by the one shared 32x32 multiplier and the key table
//   with one write and one read port; a dropped invalid point skips both, and a point takes
//   longer while a finished beat waits on the output
// reset: synchronous; a clearing pass over every table slot runs after reset and after every
//   255th frame, during which no point is taken
`default_nettype none
module voxel_grid_first_point_filter #(
  parameter int TABLE_SLOTS = vgf_pkg::VGF_TABLE_SLOTS
) (
  input wire logic     clk,
  input wire logic     rst,
  vgf_cfg_if.sink      cfg,
  vgf_point_if.sink    pt,
  vgf_result_if.source res
);
  import vgf_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int MW = VGF_EPOCH_W + VGF_KEY_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_HASH = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_DONE = 7'b0100000,
    S_CLR  = 7'b1000000
  } state_t;

  state_t state;

  logic [31:0] inv_voxel;
  logic        drop_invalid;

  logic [15:0] idx;
  logic [31:0] cx, cy, cz;
  logic        last;
  logic        keep_r, ovf_r;

  logic [2:0]  step, pstep;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [VGF_AXIS_W-1:0] kx, ky, kz;
  logic [31:0] hlo, hhi;
  logic [VGF_KEY_W-1:0] key;

  logic [AW-1:0] slot, clr_addr;
  logic [AW:0]   cnt;
  logic [VGF_EPOCH_W-1:0] epoch;

  logic [MW-1:0] mem [TABLE_SLOTS];
  logic [MW-1:0] rd_data;
  logic          hit_valid, hit_key;

  assign key       = {kz, ky, kx};
  assign cfg.ready = 1'b1;
  assign pt.ready  = (state == S_IDLE);
  assign hit_valid = (rd_data[MW-1 -: VGF_EPOCH_W] == epoch);
  assign hit_key   = (rd_data[VGF_KEY_W-1:0] == key);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (step)
      3'd0: begin mul_a = magnitude(cx); mul_b = inv_voxel; end
      3'd1: begin mul_a = magnitude(cy); mul_b = inv_voxel; end
      3'd2: begin mul_a = magnitude(cz); mul_b = inv_voxel; end
      3'd4: begin mul_a = key[31:0]; mul_b = HASH_MUL[31:0]; end
      3'd5: begin mul_a = {1'b0, key[VGF_KEY_W-1:32]}; mul_b = HASH_MUL[31:0]; end
      3'd6: begin mul_a = key[31:0]; mul_b = HASH_MUL[63:32]; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_voxel    <= INV_VOXEL_RESET;
      drop_invalid <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INV_VOXEL:  inv_voxel    <= cfg.data;
        REG_DROP_INVAL: drop_invalid <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // key table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      mem[clr_addr] <= '0;
    end else if (state == S_CMP && !hit_valid) begin
      mem[slot] <= {epoch, key};
    end
    if (state == S_RD) begin
      rd_data <= mem[slot];
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (pt.valid && pt.ready) begin
      idx  <= pt.point_index;
      cx   <= pt.coord_x;
      cy   <= pt.coord_y;
      cz   <= pt.coord_z;
      last <= pt.frame_end;
    end
    if (state == S_MUL) begin
      prod  <= 64'(mul_a) * 64'(mul_b);
      pstep <= step;
      if (step != 3'd0) begin
        case (pstep)
          3'd0: kx <= axis_key(prod[63:32], cx[31]);
          3'd1: ky <= axis_key(prod[63:32], cy[31]);
          3'd2: kz <= axis_key(prod[63:32], cz[31]);
          3'd4: begin hlo <= prod[31:0]; hhi <= prod[63:32]; end
          3'd5: hhi <= hhi + prod[31:0];
          3'd6: hhi <= hhi + prod[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      epoch     <= '0;
      step      <= '0;
      slot      <= '0;
      cnt       <= '0;
      keep_r    <= 1'b0;
      ovf_r     <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded below instead
      if (res.valid && res.ready && state != S_DONE) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pt.valid) begin
            keep_r <= 1'b0;
            ovf_r  <= 1'b0;
            step   <= '0;
            if (pt.point_invalid && drop_invalid) state <= S_DONE;
            else                                  state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 3'd1;
          if (step == 3'd7) state <= S_HASH;
        end
        S_HASH: begin
          slot  <= hlo[AW-1:0] ^ hhi[AW-1:0];
          cnt   <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (!hit_valid) begin
            keep_r <= 1'b1;
            state  <= S_DONE;
          end else if (hit_key) begin
            state <= S_DONE;
          end else if (cnt + 1'b1 == (AW+1)'(TABLE_SLOTS)) begin
            ovf_r <= 1'b1;
            state <= S_DONE;
          end else begin
            slot  <= slot + 1'b1;
            cnt   <= cnt + 1'b1;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid          <= 1'b1;
            res.kept_index     <= idx;
            res.keep           <= keep_r;
            res.table_overflow <= ovf_r;
            res.frame_done     <= last;
            // a new frame moves to the next epoch, wrap forces a clearing pass
            if (last) begin
              epoch <= epoch + 1'b1;
              if (&epoch) begin
                clr_addr <= '0;
                state    <= S_CLR;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            epoch <= VGF_EPOCH_W'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/vgf_checker.sv -----
// port-level checks for the voxel grid first point filter, bound to the top level
// uses the assertion macros header
`default_nettype none
`include "voxel_grid_first_point_filter_assert.svh"
module vgf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        cfg_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_index,
  input wire logic        out_keep,
  input wire logic        out_ovf
);
  `VGF_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")
  `VGF_ASSERT(a_keep_ovf, !(out_valid && out_keep && out_ovf), "kept and overflow together")
  `VGF_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "point taken while busy")
  `VGF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_index), "stalled beat changed")
endmodule

bind voxel_grid_first_point_filter vgf_checker u_vgf_checker (
  .clk(clk), .rst(rst), .in_valid(pt.valid), .in_ready(pt.ready), .cfg_ready(cfg.ready),
  .out_valid(res.valid), .out_ready(res.ready), .out_index(res.kept_index),
  .out_keep(res.keep), .out_ovf(res.table_overflow)
);
`default_nettype wire

// ----- tb/tb_vgf_scoreboard.sv -----
// scoreboard for the voxel grid first point filter testbench
// holds a voxel table model and the queue of predicted results; uses vgf_pkg
`timescale 1ns / 1ps
package tb_vgf_sb_pkg;
  typedef struct packed {
    logic [15:0] kept_index;
    logic        keep;
    logic        table_overflow;
    logic        frame_done;
  } filter_result_t;

  typedef struct packed {
    logic [15:0] point_index;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        point_invalid;
    logic        frame_end;
  } point_t;

  class voxel_scoreboard;
    localparam int SLOTS = vgf_pkg::VGF_TABLE_SLOTS;
    logic [31:0]   inv_size;
    logic          drop_inval;
    logic [62:0]   seen_keys [SLOTS];
    bit            occupied [SLOTS];
    int            error_count;
    int            kept_total;
    int            overflow_total;
    filter_result_t pending[$];

    function new();
      inv_size   = vgf_pkg::INV_VOXEL_RESET;
      drop_inval = 1'b1;
      clear_voxels();
    endfunction

    function void clear_voxels();
      foreach (occupied[i]) occupied[i] = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      if (idx == vgf_pkg::REG_INV_VOXEL) inv_size = data;
      else if (idx == vgf_pkg::REG_DROP_INVAL) drop_inval = data[0];
    endfunction

    function logic [20:0] scale_axis(logic [31:0] c);
      logic [32:0] mag;
      logic [64:0] prod;
      logic [32:0] q;
      mag  = c[31] ? (33'h1_0000_0000 - {1'b0, c}) : {1'b0, c};
      prod = mag * inv_size;
      q    = prod[64:32];
      if (c[31]) begin
        if (q > 33'd1048576) q = 33'd1048576;
        return 21'(33'd0 - q);
      end
      if (q > 33'd1048575) q = 33'd1048575;
      return q[20:0];
    endfunction

    function void note_point(point_t p);
      filter_result_t r;
      logic [62:0]    k;
      logic [63:0]    h;
      int             s;
      r = '0;
      r.kept_index = p.point_index;
      r.frame_done = p.frame_end;
      if (!(p.point_invalid && drop_inval)) begin
        k = {scale_axis(p.coord_z), scale_axis(p.coord_y), scale_axis(p.coord_x)};
        h = {1'b0, k} * 64'h9E37_79B9_7F4A_7C15;
        h = h ^ (h >> 32);
        s = int'(h % SLOTS);
        r.table_overflow = 1'b1;
        for (int n = 0; n < SLOTS; n++) begin
          if (!occupied[s]) begin
            occupied[s] = 1; seen_keys[s] = k;
            r.keep = 1'b1; r.table_overflow = 1'b0;
            break;
          end
          if (seen_keys[s] == k) begin
            r.table_overflow = 1'b0;
            break;
          end
          s = (s + 1) % SLOTS;
        end
      end
      if (p.frame_end) clear_voxels();
      pending = {pending, r};
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      error_count++;
    endtask

    task check_result(filter_result_t got);
      filter_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result index %0d", got.kept_index));
        return;
      end
      want = pending.pop_front();
      if (got.kept_index !== want.kept_index)
        report($sformatf("kept_index %0d want %0d", got.kept_index, want.kept_index));
      if (got.keep !== want.keep)
        report($sformatf("keep %b want %b at %0d", got.keep, want.keep, want.kept_index));
      if (got.table_overflow !== want.table_overflow)
        report($sformatf("table_overflow %b want %b at %0d", got.table_overflow,
                         want.table_overflow, want.kept_index));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done %b want %b at %0d", got.frame_done, want.frame_done,
                         want.kept_index));
      kept_total += got.keep;
      overflow_total += got.table_overflow;
    endtask
  endclass
endpackage

// ----- tb/tb_top.sv -----
// top of the voxel grid first point filter testbench
// depends on vgf_pkg, vgf_if and tb_vgf_sb_pkg
`timescale 1ns / 1ps
module tb_top;
  import tb_vgf_sb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  vgf_cfg_if    cfg ();
  vgf_point_if  pt ();
  vgf_result_if res ();

  voxel_grid_first_point_filter uut (.clk(clk), .rst(rst), .cfg(cfg), .pt(pt), .res(res));

  voxel_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  int cycle_count = 0;
  int points_sent = 0;
  logic [15:0] next_index = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cfg.valid = 0; cfg.index = '0; cfg.data = '0;
    pt.valid = 0; pt.point_index = '0; pt.coord_x = '0; pt.coord_y = '0; pt.coord_z = '0;
    pt.point_invalid = 0; pt.frame_end = 0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      board.check_result('{res.kept_index, res.keep, res.table_overflow, res.frame_done});
    res.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    board.write_reg(idx, data);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic inval, logic last);
    point_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      pt.valid <= 0;
      @(posedge clk);
    end
    p = '{next_index, x, y, z, inval, last};
    pt.valid <= 1; pt.point_index <= p.point_index;
    pt.coord_x <= x; pt.coord_y <= y; pt.coord_z <= z;
    pt.point_invalid <= inval; pt.frame_end <= last;
    do @(posedge clk); while (!pt.ready);
    board.note_point(p);
    points_sent++;
    next_index = last ? 16'd0 : next_index + 16'd1;
  endtask

  task automatic drain();
    pt.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // coordinate mostly near a small cluster, sometimes anywhere or at an extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  task automatic random_frame(int len);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(15) == 0,
                 i == len - 1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, repeats, invalid, saturation
    send_point(32'h0, 32'h0, 32'h0, 0, 0);
    send_point(32'h0, 32'h0, 32'h0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_point(32'h1_0000, 32'hFFFF_0000, 32'h0, 1, 0);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0, 0, 0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1);
    send_point(32'h0, 32'h0, 32'h0, 0, 1);
    drain();
    write_reg(vgf_pkg::REG_INV_VOXEL, 32'hFFFF_FFFF);
    write_reg(vgf_pkg::REG_DROP_INVAL, 32'd0);
    write_reg(8'd7, 32'd5);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0);
    send_point(32'h0, 32'hFFFF_FFFF, 32'h0, 0, 1);
    drain();
    write_reg(vgf_pkg::REG_INV_VOXEL, 32'd0);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 0, 1);
    drain();

    // random phases with different scales and idling
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(vgf_pkg::REG_INV_VOXEL,
                ph == 0 ? 32'd1 : ph == 5 ? 32'hFFFF_FFFF : $urandom_range(32'h4_0000, 1));
      write_reg(vgf_pkg::REG_DROP_INVAL, ph[0]);
      send_idle_pct = ph < 2 ? 7 : ph < 4 ? 67 : 0;
      recv_idle_pct = ph < 2 ? 67 : ph < 4 ? 7 : 0;
      if (ph == 4) fork
        begin
          hold_off = 1;
          repeat (600) @(posedge clk);
          hold_off = 0;
        end
      join_none
      while (points_sent < 30 + (ph + 1) * 300) random_frame($urandom_range(80, 1));
      drain();
    end

    $display("covered %0d points: %0d kept, %0d table overflows", points_sent,
             board.kept_total, board.overflow_total);
    if (board.pending.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending.size()));
    if (board.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
